>>> design/cpcf_pkg.sv
// ----------------------------------------------------------------------------
// cpcf_pkg
// Shared widths, register codes and sideband types of the disc pair
// contact force pipeline.
// ----------------------------------------------------------------------------
package cpcf_pkg;

	localparam int W          = 32;        // value word width
	localparam int F          = 16;        // fraction bits
	localparam int RW         = W - 1;     // radius width
	localparam int SQRT_BITS  = 2 * W;     // radicand width
	localparam int SQRT_STAGES = W / 2;    // two root bits per stage
	localparam int DIR_BITS   = F + 1;     // unit normal magnitude, up to 1.0
	localparam int DIV_STAGES = (DIR_BITS + 1) / 2;

	// configuration register indexes
	localparam logic [0:0] REG_STIFFNESS = 1'b0;
	localparam logic [0:0] REG_DAMPING   = 1'b1;

	localparam logic [W-1:0] STIFFNESS_RST = W'(1) << F;
	localparam logic [W-1:0] DAMPING_RST   = '0;

	localparam logic signed [W-1:0] FORCE_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] FORCE_MIN = {1'b1, {(W-1){1'b0}}};

	// geometry and velocity of one pair, carried beside the root and divide
	typedef struct packed {
		logic [W-1:0]        adx;
		logic [W-1:0]        ady;
		logic                sx;
		logic                sy;
		logic signed [W:0]   rvx;
		logic signed [W:0]   rvy;
		logic [W-1:0]        coll;
		logic                contact;
		logic                active;
	} pair_t;

	// what the force stages carry along
	typedef struct packed {
		logic [DIR_BITS-1:0] dirx;
		logic [DIR_BITS-1:0] diry;
		logic                sx;
		logic                sy;
		logic                contact;
		logic                active;
	} side_t;

endpackage

>>> design/cpcf_front.sv
// ----------------------------------------------------------------------------
// cpcf_front
// Center deltas, relative velocity, squared distance and overlap test.
// Three stages.
// ----------------------------------------------------------------------------
module cpcf_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_v,
	input  logic signed [cpcf_pkg::W-1:0]   a_pos_x,
	input  logic signed [cpcf_pkg::W-1:0]   a_pos_y,
	input  logic signed [cpcf_pkg::W-1:0]   a_vel_x,
	input  logic signed [cpcf_pkg::W-1:0]   a_vel_y,
	input  logic [cpcf_pkg::RW-1:0]         a_radius,
	input  logic signed [cpcf_pkg::W-1:0]   b_pos_x,
	input  logic signed [cpcf_pkg::W-1:0]   b_pos_y,
	input  logic signed [cpcf_pkg::W-1:0]   b_vel_x,
	input  logic signed [cpcf_pkg::W-1:0]   b_vel_y,
	input  logic [cpcf_pkg::RW-1:0]         b_radius,
	output logic                            out_v,
	output cpcf_pkg::pair_t                 pair,
	output logic [cpcf_pkg::SQRT_BITS-1:0]  sum
);
	import cpcf_pkg::*;

	logic signed [W:0] dx, dy;
	logic [W:0]        adx, ady;
	logic [W-1:0]      coll;
	logic              near;

	logic              v_s1, v_s2, v_s3;
	pair_t             p_s1, p_s2, p_s3;
	logic              near_s1, near_s2;
	logic [2*W-1:0]    sqx_s2, sqy_s2, csq_s2;
	logic [2*W-1:0]    sum_s3;
	logic [2*W:0]      sum_full;
	logic              hit_d3;
	pair_t             p_d3;

	// deltas and the bounding box test
	assign dx   = {a_pos_x[W-1], a_pos_x} - {b_pos_x[W-1], b_pos_x};
	assign dy   = {a_pos_y[W-1], a_pos_y} - {b_pos_y[W-1], b_pos_y};
	assign adx  = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
	assign ady  = dy[W] ? (W+1)'(-dy) : (W+1)'(dy);
	assign coll = {1'b0, a_radius} + {1'b0, b_radius};
	assign near = (adx < {1'b0, coll}) && (ady < {1'b0, coll});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: register deltas
	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1.adx     <= adx[W-1:0];
			p_s1.ady     <= ady[W-1:0];
			p_s1.sx      <= dx[W];
			p_s1.sy      <= dy[W];
			p_s1.rvx     <= {a_vel_x[W-1], a_vel_x} - {b_vel_x[W-1], b_vel_x};
			p_s1.rvy     <= {a_vel_y[W-1], a_vel_y} - {b_vel_y[W-1], b_vel_y};
			p_s1.coll    <= coll;
			p_s1.contact <= 1'b0;
			p_s1.active  <= 1'b0;
			near_s1      <= near;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2  <= (2*W)'(p_s1.adx) * (2*W)'(p_s1.adx);
			sqy_s2  <= (2*W)'(p_s1.ady) * (2*W)'(p_s1.ady);
			csq_s2  <= (2*W)'(p_s1.coll) * (2*W)'(p_s1.coll);
			p_s2    <= p_s1;
			near_s2 <= near_s1;
		end
	end

	// stage 3: squared distance against squared radius sum
	assign sum_full = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_comb begin
		hit_d3       = near_s2 && !sum_full[2*W] && (sum_full[2*W-1:0] < csq_s2);
		p_d3         = p_s2;
		p_d3.contact = hit_d3;
		p_d3.active  = hit_d3 && (sum_full[2*W-1:0] != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3   <= p_d3;
			sum_s3 <= sum_full[2*W-1:0];
		end
	end

	assign out_v = v_s3;
	assign pair  = p_s3;
	assign sum   = sum_s3;

endmodule

>>> design/cpcf_sqrt.sv
// ----------------------------------------------------------------------------
// cpcf_sqrt
// Pipelined integer square root, two result bits per stage.
// ----------------------------------------------------------------------------
module cpcf_sqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_v,
	input  cpcf_pkg::pair_t                 in_pair,
	input  logic [cpcf_pkg::SQRT_BITS-1:0]  sum,
	output logic                            out_v,
	output cpcf_pkg::pair_t                 out_pair,
	output logic [cpcf_pkg::W-1:0]          sep
);
	import cpcf_pkg::*;

	localparam int N = SQRT_STAGES;

	logic              v_s    [1:N];
	logic [W+1:0]      rem_s  [1:N];
	logic [W-1:0]      root_s [1:N];
	logic [2*W-1:0]    rad_s  [1:N];
	pair_t             pair_s [1:N];

	// one restoring root step: returns {remainder, root}
	function automatic logic [2*W+1:0] sq_step(logic [W+1:0] rem, logic [W-1:0] root,
		logic [1:0] bits);
		logic [W+3:0] r2;
		logic [W+3:0] t;
		r2 = {rem, bits};
		t  = {2'b00, root, 2'b01};
		if (r2 >= t)
			return {(W+2)'(r2 - t), root[W-2:0], 1'b1};
		else
			return {r2[W+1:0], root[W-2:0], 1'b0};
	endfunction

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [W+1:0]   rin;
		logic [W-1:0]   qin;
		logic [2*W-1:0] din;
		pair_t          pin;
		logic           vin;
		logic [2*W+1:0] st1, st2;

		if (i == 0) begin : g_in
			assign rin = '0;
			assign qin = '0;
			assign din = sum;
			assign pin = in_pair;
			assign vin = in_v;
		end else begin : g_mid
			assign rin = rem_s[i];
			assign qin = root_s[i];
			assign din = rad_s[i];
			assign pin = pair_s[i];
			assign vin = v_s[i];
		end

		assign st1 = sq_step(rin, qin, din[2*W-1:2*W-2]);
		assign st2 = sq_step(st1[2*W+1:W], st1[W-1:0], din[2*W-3:2*W-4]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (adv)
				v_s[i+1] <= vin;
		end

		// advance remainder, partial root and the unused radicand bits
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[i+1]  <= st2[2*W+1:W];
				root_s[i+1] <= st2[W-1:0];
				rad_s[i+1]  <= {din[2*W-5:0], 4'b0000};
				pair_s[i+1] <= pin;
			end
		end
	end

	assign out_v    = v_s[N];
	assign out_pair = pair_s[N];
	assign sep      = root_s[N];

endmodule

>>> design/cpcf_div.sv
// ----------------------------------------------------------------------------
// cpcf_div
// Two pipelined restoring dividers forming the unit normal |d| / dist,
// two quotient bits per stage.
// ----------------------------------------------------------------------------
module cpcf_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_v,
	input  cpcf_pkg::pair_t                 in_pair,
	input  logic [cpcf_pkg::W-1:0]          in_dist,
	output logic                            out_v,
	output cpcf_pkg::pair_t                 out_pair,
	output logic [cpcf_pkg::W-1:0]          out_dist,
	output logic [cpcf_pkg::DIR_BITS-1:0]   dirx,
	output logic [cpcf_pkg::DIR_BITS-1:0]   diry
);
	import cpcf_pkg::*;

	localparam int N = DIV_STAGES;
	localparam int Q = DIR_BITS;

	logic          v_s    [1:N];
	logic [W-1:0]  rx_s   [1:N];
	logic [W-1:0]  ry_s   [1:N];
	logic [Q-1:0]  qx_s   [1:N];
	logic [Q-1:0]  qy_s   [1:N];
	logic [W-1:0]  d_s    [1:N];
	pair_t         pair_s [1:N];

	// one restoring divide step: returns {remainder, quotient}
	function automatic logic [W+Q-1:0] dv_step(logic [W-1:0] rem, logic [Q-1:0] q,
		logic [W-1:0] d, logic b);
		logic [W:0] r2;
		r2 = {rem, b};
		if (r2 >= {1'b0, d})
			return {W'(r2 - {1'b0, d}), q[Q-2:0], 1'b1};
		else
			return {r2[W-1:0], q[Q-2:0], 1'b0};
	endfunction

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [W-1:0]   rxi, ryi, di;
		logic [Q-1:0]   qxi, qyi;
		pair_t          pin;
		logic           vin, bx, by;
		logic [W+Q-1:0] x1, y1, x2, y2;

		// the numerator is |d| << F: its low bit of |d| enters on the first step
		if (i == 0) begin : g_in
			assign rxi = {1'b0, in_pair.adx[W-1:1]};
			assign ryi = {1'b0, in_pair.ady[W-1:1]};
			assign qxi = '0;
			assign qyi = '0;
			assign di  = in_dist;
			assign pin = in_pair;
			assign vin = in_v;
			assign bx  = in_pair.adx[0];
			assign by  = in_pair.ady[0];
		end else begin : g_mid
			assign rxi = rx_s[i];
			assign ryi = ry_s[i];
			assign qxi = qx_s[i];
			assign qyi = qy_s[i];
			assign di  = d_s[i];
			assign pin = pair_s[i];
			assign vin = v_s[i];
			assign bx  = 1'b0;
			assign by  = 1'b0;
		end

		assign x1 = dv_step(rxi, qxi, di, bx);
		assign y1 = dv_step(ryi, qyi, di, by);
		// the last stage has one step left when the quotient width is odd
		assign x2 = (2 * i + 1 < Q) ? dv_step(x1[W+Q-1:Q], x1[Q-1:0], di, 1'b0) : x1;
		assign y2 = (2 * i + 1 < Q) ? dv_step(y1[W+Q-1:Q], y1[Q-1:0], di, 1'b0) : y1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				v_s[i+1] <= 1'b0;
			else if (adv)
				v_s[i+1] <= vin;
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				rx_s[i+1]   <= x2[W+Q-1:Q];
				qx_s[i+1]   <= x2[Q-1:0];
				ry_s[i+1]   <= y2[W+Q-1:Q];
				qy_s[i+1]   <= y2[Q-1:0];
				d_s[i+1]    <= di;
				pair_s[i+1] <= pin;
			end
		end
	end

	assign out_v    = v_s[N];
	assign out_pair = pair_s[N];
	assign out_dist = d_s[N];
	assign dirx     = qx_s[N];
	assign diry     = qy_s[N];

endmodule

>>> design/cpcf_force.sv
// ----------------------------------------------------------------------------
// cpcf_force
// Normal speed, spring-dashpot magnitude and force components with
// saturation. Eight stages, the last one is the output register.
// ----------------------------------------------------------------------------
module cpcf_force (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            adv,
	input  logic                            in_v,
	input  cpcf_pkg::pair_t                 pair,
	input  logic [cpcf_pkg::W-1:0]          sep,
	input  logic [cpcf_pkg::DIR_BITS-1:0]   dirx,
	input  logic [cpcf_pkg::DIR_BITS-1:0]   diry,
	input  logic [cpcf_pkg::W-1:0]          stiffness,
	input  logic [cpcf_pkg::W-1:0]          damping,
	output logic                            out_v,
	output logic signed [cpcf_pkg::W-1:0]   force_x,
	output logic signed [cpcf_pkg::W-1:0]   force_y,
	output logic                            in_contact,
	output logic                            saturated
);
	import cpcf_pkg::*;

	localparam int Q  = DIR_BITS;
	localparam int PW = W + 2;            // projected speed magnitude
	localparam int SW = W + 3;            // |s|
	localparam int SL = SW / 2;           // low split of |s|
	localparam int CW = W + 20;           // |coef|
	localparam int CL = CW / 2;           // low split of |coef|
	localparam int MW = 62;               // capped magnitude width
	localparam int ML = MW / 2;           // low split of m
	localparam logic [MW-1:0] CAP = MW'(1) << (MW - 1);

	logic [W:0]          rvxm, rvym;
	logic [W+Q:0]        pxp, pyp;
	logic signed [PW+1:0] s;
	logic [W+SL-1:0]     dlo;
	logic [2*W+SW-SL-1:0] dprod;
	logic [W+CL-1:0]     mlo;
	logic signed [CW:0]  coef;
	logic [W+CW-1:0]     mprod;
	logic [W+CW-F-1:0]   mq;
	logic [MW+Q-1:0]     fxp, fyp;

	logic [7:0]          v_q;
	side_t               sd_s1, sd_s2, sd_s3, sd_s4, sd_s5, sd_s6, sd_s7;
	logic [PW-1:0]       pxm_s1, pym_s1;
	logic                pxn_s1, pyn_s1;
	logic [W-1:0]        dev_s1, dev_s2, dev_s3, dev_s4;
	logic [SW-1:0]       smag_s2;
	logic                sneg_s2, sneg_s3;
	logic [W+SL-1:0]     dl_s3;
	logic [W+SW-SL-1:0]  dh_s3;
	logic [CW-1:0]       cmag_s4;
	logic                cneg_s4, cneg_s5;
	logic [W+CL-1:0]     ml_s5;
	logic [W+CW-CL-1:0]  mh_s5;
	logic [MW-1:0]       m_s6;
	logic                mneg_s6, mneg_s7;
	logic [ML+Q-1:0]     fxl_s7, fyl_s7;
	logic [MW-ML+Q-1:0]  fxh_s7, fyh_s7;
	logic signed [W-1:0] fx_s8, fy_s8;
	logic                cont_s8, sat_s8;
	logic [W:0]          clx, cly;

	// clamp a magnitude with a sign to the output range: {saturated, value}
	function automatic logic [W:0] clamp(logic [MW+Q-F-1:0] mag, logic neg);
		if (!neg) begin
			if (mag > (MW+Q-F)'(FORCE_MAX))
				return {1'b1, FORCE_MAX};
			else
				return {1'b0, mag[W-1:0]};
		end else begin
			if (mag > (MW+Q-F)'(FORCE_MAX) + (MW+Q-F)'(1))
				return {1'b1, FORCE_MIN};
			else
				return {1'b0, W'(-mag[W-1:0])};
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (adv)
			v_q <= {v_q[6:0], in_v};
	end

	// stage 1: project relative velocity on the normal, overlap depth
	assign rvxm = pair.rvx[W] ? (W+1)'(-pair.rvx) : (W+1)'(pair.rvx);
	assign rvym = pair.rvy[W] ? (W+1)'(-pair.rvy) : (W+1)'(pair.rvy);
	assign pxp  = (W+Q+1)'(dirx) * (W+Q+1)'(rvxm);
	assign pyp  = (W+Q+1)'(diry) * (W+Q+1)'(rvym);

	always_ff @(posedge clk) begin
		if (adv) begin
			pxm_s1        <= pxp[W+Q:F];
			pym_s1        <= pyp[W+Q:F];
			pxn_s1        <= pair.sx ^ pair.rvx[W];
			pyn_s1        <= pair.sy ^ pair.rvy[W];
			dev_s1        <= pair.coll - sep;
			sd_s1.dirx    <= dirx;
			sd_s1.diry    <= diry;
			sd_s1.sx      <= pair.sx;
			sd_s1.sy      <= pair.sy;
			sd_s1.contact <= pair.contact;
			sd_s1.active  <= pair.active;
		end
	end

	// stage 2: normal relative speed s
	assign s = (pxn_s1 ? -(PW+2)'(pxm_s1) : (PW+2)'(pxm_s1))
		+ (pyn_s1 ? -(PW+2)'(pym_s1) : (PW+2)'(pym_s1));

	always_ff @(posedge clk) begin
		if (adv) begin
			smag_s2 <= s[PW+1] ? SW'(-s) : SW'(s);
			sneg_s2 <= s[PW+1];
			dev_s2  <= dev_s1;
			sd_s2   <= sd_s1;
		end
	end

	// stage 3: damping times |s| in two partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			dl_s3   <= (W+SL)'(damping) * (W+SL)'(smag_s2[SL-1:0]);
			dh_s3   <= (W+SW-SL)'(damping) * (W+SW-SL)'(smag_s2[SW-1:SL]);
			sneg_s3 <= sneg_s2;
			dev_s3  <= dev_s2;
			sd_s3   <= sd_s2;
		end
	end

	// stage 4: coef = stiffness - damping*s
	assign dlo   = dl_s3;
	assign dprod = (2*W+SW-SL)'(dlo) + {dh_s3, SL'(0)};
	assign coef  = sneg_s3 ? (CW+1)'(stiffness) + (CW+1)'(dprod[2*W+SW-SL-1:F])
		: (CW+1)'(stiffness) - (CW+1)'(dprod[2*W+SW-SL-1:F]);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmag_s4 <= coef[CW] ? CW'(-coef) : CW'(coef);
			cneg_s4 <= coef[CW];
			dev_s4  <= dev_s3;
			sd_s4   <= sd_s3;
		end
	end

	// stage 5: dev times |coef| in two partial products
	always_ff @(posedge clk) begin
		if (adv) begin
			ml_s5   <= (W+CL)'(dev_s4) * (W+CL)'(cmag_s4[CL-1:0]);
			mh_s5   <= (W+CW-CL)'(dev_s4) * (W+CW-CL)'(cmag_s4[CW-1:CL]);
			cneg_s5 <= cneg_s4;
			sd_s5   <= sd_s4;
		end
	end

	// stage 6: combine, scale and cap the magnitude m
	assign mlo   = ml_s5;
	assign mprod = (W+CW)'(mlo) + {mh_s5, CL'(0)};
	assign mq    = mprod[W+CW-1:F];

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s6    <= (mq > (W+CW-F)'(CAP)) ? CAP : mq[MW-1:0];
			mneg_s6 <= cneg_s5;
			sd_s6   <= sd_s5;
		end
	end

	// stage 7: m times each normal component in two halves
	always_ff @(posedge clk) begin
		if (adv) begin
			fxl_s7  <= (ML+Q)'(m_s6[ML-1:0]) * (ML+Q)'(sd_s6.dirx);
			fxh_s7  <= (MW-ML+Q)'(m_s6[MW-1:ML]) * (MW-ML+Q)'(sd_s6.dirx);
			fyl_s7  <= (ML+Q)'(m_s6[ML-1:0]) * (ML+Q)'(sd_s6.diry);
			fyh_s7  <= (MW-ML+Q)'(m_s6[MW-1:ML]) * (MW-ML+Q)'(sd_s6.diry);
			mneg_s7 <= mneg_s6;
			sd_s7   <= sd_s6;
		end
	end

	// stage 8: scale, clamp and drop the force outside contact
	assign fxp = (MW+Q)'(fxl_s7) + {fxh_s7, ML'(0)};
	assign fyp = (MW+Q)'(fyl_s7) + {fyh_s7, ML'(0)};
	assign clx = clamp(fxp[MW+Q-1:F], mneg_s7 ^ sd_s7.sx);
	assign cly = clamp(fyp[MW+Q-1:F], mneg_s7 ^ sd_s7.sy);

	always_ff @(posedge clk) begin
		if (adv) begin
			fx_s8   <= sd_s7.active ? clx[W-1:0] : '0;
			fy_s8   <= sd_s7.active ? cly[W-1:0] : '0;
			sat_s8  <= sd_s7.active && (clx[W] || cly[W]);
			cont_s8 <= sd_s7.contact;
		end
	end

	assign out_v      = v_q[7];
	assign force_x    = fx_s8;
	assign force_y    = fy_s8;
	assign in_contact = cont_s8;
	assign saturated  = sat_s8;

endmodule

>>> design/circle_pair_contact_force.sv
// ----------------------------------------------------------------------------
// circle_pair_contact_force
// Spring-dashpot contact force between two discs, Q16.16, fully pipelined.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   a_*, b_* disc fields
//   out      result     out_valid / out_stall force_x, force_y, in_contact,
//                                             saturated
//   cfg      write      cfg_write             cfg_index, cfg_data
//
// One pair enters per cycle while the input is not stalled; each result passes
// through 3 front, 16 square root, 9 divide and 8 force stages.
// A stalled result freezes every stage, so requests are refused only while
// the output register holds a result that is not taken.
// Reset clears the valid bits and loads stiffness 1.0 and damping 0.
// ----------------------------------------------------------------------------
module circle_pair_contact_force (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [cpcf_pkg::W-1:0]   a_pos_x,
	input  logic signed [cpcf_pkg::W-1:0]   a_pos_y,
	input  logic signed [cpcf_pkg::W-1:0]   a_vel_x,
	input  logic signed [cpcf_pkg::W-1:0]   a_vel_y,
	input  logic [cpcf_pkg::RW-1:0]         a_radius,
	input  logic signed [cpcf_pkg::W-1:0]   b_pos_x,
	input  logic signed [cpcf_pkg::W-1:0]   b_pos_y,
	input  logic signed [cpcf_pkg::W-1:0]   b_vel_x,
	input  logic signed [cpcf_pkg::W-1:0]   b_vel_y,
	input  logic [cpcf_pkg::RW-1:0]         b_radius,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [cpcf_pkg::W-1:0]   force_x,
	output logic signed [cpcf_pkg::W-1:0]   force_y,
	output logic                            in_contact,
	output logic                            saturated,
	input  logic                            cfg_write,
	input  logic [0:0]                      cfg_index,
	input  logic [cpcf_pkg::W-1:0]          cfg_data
);
	import cpcf_pkg::*;

	logic         adv;
	logic [W-1:0] stiffness_q, damping_q;
	logic         fr_v, sq_v, dv_v;
	pair_t        fr_pair, sq_pair, dv_pair;
	logic [2*W-1:0] fr_sum;
	logic [W-1:0] sq_dist, dv_dist;
	logic [DIR_BITS-1:0] dirx, diry;

	// advance everything unless a finished result is held
	assign adv      = !out_valid || !out_stall;
	assign in_stall = !adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiffness_q <= STIFFNESS_RST;
			damping_q   <= DAMPING_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_STIFFNESS: stiffness_q <= cfg_data;
				REG_DAMPING:   damping_q   <= cfg_data;
				default:       ;
			endcase
		end
	end

	cpcf_front u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(in_valid),
		.a_pos_x(a_pos_x), .a_pos_y(a_pos_y), .a_vel_x(a_vel_x), .a_vel_y(a_vel_y),
		.a_radius(a_radius),
		.b_pos_x(b_pos_x), .b_pos_y(b_pos_y), .b_vel_x(b_vel_x), .b_vel_y(b_vel_y),
		.b_radius(b_radius),
		.out_v(fr_v), .pair(fr_pair), .sum(fr_sum)
	);

	cpcf_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(fr_v),
		.in_pair(fr_pair), .sum(fr_sum),
		.out_v(sq_v), .out_pair(sq_pair), .sep(sq_dist)
	);

	cpcf_div u_div (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(sq_v),
		.in_pair(sq_pair), .in_dist(sq_dist),
		.out_v(dv_v), .out_pair(dv_pair), .out_dist(dv_dist),
		.dirx(dirx), .diry(diry)
	);

	cpcf_force u_force (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(dv_v),
		.pair(dv_pair), .sep(dv_dist), .dirx(dirx), .diry(diry),
		.stiffness(stiffness_q), .damping(damping_q),
		.out_v(out_valid), .force_x(force_x), .force_y(force_y),
		.in_contact(in_contact), .saturated(saturated)
	);

endmodule

>>> design/cpcf_check.sv
// ----------------------------------------------------------------------------
// cpcf_check
// Port-level checks of the contact force pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module cpcf_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic signed [cpcf_pkg::W-1:0]   force_x,
	input logic signed [cpcf_pkg::W-1:0]   force_y,
	input logic                            in_contact,
	input logic                            saturated
);
	import cpcf_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(force_x) && $stable(force_y)
			&& $stable(in_contact) && $stable(saturated))
		else $error("held result changed");

	// requests are refused only behind a blocked result
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked result");

	// no contact means no force
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_contact |-> force_x == '0 && force_y == '0 && !saturated)
		else $error("force without contact");

	// a clamped result sits on a bound
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> force_x == FORCE_MAX || force_x == FORCE_MIN
			|| force_y == FORCE_MAX || force_y == FORCE_MIN)
		else $error("saturated flag without a bound value");

endmodule

bind circle_pair_contact_force cpcf_check u_check (.*);
